>>> rtl/core/sfst_pkg.sv
// sfst_pkg: shared constants and types of the size sorted free space table
// depends on nothing; used by every file of the block

package sfst_pkg;

  // default table depth
  localparam int DEPTH_DEF = 64;

  // fixed field widths
  localparam int TYPE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  // request types
  localparam logic [TYPE_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // one captured request
  typedef struct packed {
    logic [TYPE_W-1:0]   req_type;
    logic [KEY_W-1:0]    size_key;
    logic [HANDLE_W-1:0] space_handle;
    logic [IDX_W-1:0]    entry_index;
  } req_t;

  // result flags handed from the engine to the output register
  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
  } rsp_flags_t;

endpackage

>>> rtl/core/size_sorted_free_space_table.sv
// size_sorted_free_space_table: top level, request handshake and result register
// depends on sfst_pkg and sfst_engine
//
//  channel  | direction | handshake        | payload
//  in_      | request   | in_valid/stall   | req_type, size_key, space_handle, entry_index
//  out_     | result    | out_valid/stall  | found, result_index, result_handle,
//           |           |                  | entry_count, status
//
// one request at a time; find, and insert into a table neither empty nor full, first
// run a binary search with one memory read per probe (at most log2(DEPTH)+1 probes);
// insert then moves the entries from the insert position up one slot, remove
// moves the entries above the index down one slot, one entry moved per cycle
// through the single read and single write port of the entry memory
// rst_n clears the entry count; the memory keeps its contents and needs no pass
// in_stall is high in reset and while a request is at work; a waiting result
// holds in the output register and the next request is taken meanwhile

module size_sorted_free_space_table #(
  parameter int DEPTH = sfst_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfst_pkg::TYPE_W-1:0]   in_req_type,
  input  logic [sfst_pkg::KEY_W-1:0]    in_size_key,
  input  logic [sfst_pkg::HANDLE_W-1:0] in_space_handle,
  input  logic [sfst_pkg::IDX_W-1:0]    in_entry_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [$clog2(DEPTH+1)-1:0]    out_result_index,
  output logic [sfst_pkg::HANDLE_W-1:0] out_result_handle,
  output logic [$clog2(DEPTH+1)-1:0]    out_entry_count,
  output logic [sfst_pkg::STATUS_W-1:0] out_status
);

  localparam int CW = $clog2(DEPTH + 1);

  sfst_pkg::req_t       req;
  sfst_pkg::rsp_flags_t rsp_flags;
  logic                 eng_idle, rsp_valid, rsp_take, in_accept, out_free;
  logic [CW-1:0]        rsp_index, rsp_count;
  logic [sfst_pkg::HANDLE_W-1:0] rsp_handle;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r;
  logic [CW-1:0]                 out_index_r, out_count_r;
  logic [sfst_pkg::HANDLE_W-1:0] out_handle_r;
  logic [sfst_pkg::STATUS_W-1:0] out_status_r;

  // request capture
  assign in_stall         = !rst_n || !eng_idle;
  assign in_accept        = in_valid && !in_stall;
  assign req.req_type     = in_req_type;
  assign req.size_key     = in_size_key;
  assign req.space_handle = in_space_handle;
  assign req.entry_index  = in_entry_index;

  sfst_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .req       (req),
    .idle      (eng_idle),
    .rsp_valid (rsp_valid),
    .rsp_take  (rsp_take),
    .rsp_flags (rsp_flags),
    .rsp_index (rsp_index),
    .rsp_handle(rsp_handle),
    .rsp_count (rsp_count)
  );

  // result register
  assign out_free = !out_valid_r || !out_stall;
  assign rsp_take = rsp_valid && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_found_r  <= rsp_flags.found;
      out_status_r <= rsp_flags.status;
      out_index_r  <= rsp_index;
      out_handle_r <= rsp_handle;
      out_count_r  <= rsp_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_result_index  = out_index_r;
  assign out_result_handle = out_handle_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = out_status_r;

endmodule

>>> rtl/core/sfst_engine.sv
// sfst_engine: sequencer, entry memory and entry count of the free space table
// depends on sfst_pkg

module sfst_engine #(
  parameter int DEPTH = sfst_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  sfst_pkg::req_t               req,
  output logic                         idle,
  output logic                         rsp_valid,
  input  logic                         rsp_take,
  output sfst_pkg::rsp_flags_t         rsp_flags,
  output logic [$clog2(DEPTH+1)-1:0]   rsp_index,
  output logic [sfst_pkg::HANDLE_W-1:0] rsp_handle,
  output logic [$clog2(DEPTH+1)-1:0]   rsp_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > sfst_pkg::IDX_W) ? CW : sfst_pkg::IDX_W;
  localparam int HW = sfst_pkg::HANDLE_W;
  localparam int KW = sfst_pkg::KEY_W;
  localparam int WW = KW + HW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_CMP   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  sfst_pkg::req_t               req_r, req_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                lo_r, lo_nxt, hi_r, hi_nxt, g_r, g_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic                         hit_r, hit_nxt;
  logic [sfst_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [AW-1:0]                rd_ptr_r, rd_ptr_nxt, last_r, last_nxt;
  logic                         up_r, up_nxt, rd_more_r, rd_more_nxt;
  logic                         wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]                wr_addr_r, wr_addr_nxt;

  // memory ports
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] mem_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_data;

  // helper values
  logic [AW:0]   mid_sum;
  logic [AW-1:0] cnt_m1;
  logic [KW-1:0] probe_size;
  logic [CW-1:0] pos_calc;
  logic [IW:0]   idx_p1;

  assign cnt_m1     = AW'(count_r - CW'(1));
  assign probe_size = mem_q[WW-1:HW];
  assign idx_p1     = {1'b0, IW'(req.entry_index)} + (IW+1)'(1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    g_nxt       = g_r;
    pos_nxt     = pos_r;
    hit_nxt     = hit_r;
    status_nxt  = status_r;
    rd_ptr_nxt  = rd_ptr_r;
    last_nxt    = last_r;
    up_nxt      = up_r;
    rd_more_nxt = rd_more_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    rd_en       = 1'b0;
    rd_addr     = g_r;
    wr_en       = 1'b0;
    wr_addr     = wr_addr_r;
    wr_data     = mem_q;
    mid_sum     = '0;
    pos_calc    = pos_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = req;
          hit_nxt    = 1'b0;
          pos_nxt    = '0;
          status_nxt = sfst_pkg::ST_OK;
          lo_nxt     = '0;
          hi_nxt     = cnt_m1;
          mid_sum    = {1'b0, cnt_m1};
          g_nxt      = mid_sum[AW:1];
          wr_pend_nxt = 1'b0;
          case (req.req_type)
            sfst_pkg::REQ_FIND: begin
              state_nxt = (count_r == '0) ? S_DONE : S_RD;
            end
            sfst_pkg::REQ_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = sfst_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else if (count_r == '0) begin
                up_nxt      = 1'b1;
                rd_more_nxt = 1'b0;
                state_nxt   = S_SHIFT;
              end else begin
                state_nxt = S_RD;
              end
            end
            sfst_pkg::REQ_REMOVE: begin
              if (IW'(req.entry_index) >= IW'(count_r)) begin
                status_nxt = sfst_pkg::ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                up_nxt      = 1'b0;
                rd_ptr_nxt  = AW'(idx_p1);
                last_nxt    = cnt_m1;
                rd_more_nxt = idx_p1 < (IW+1)'(count_r);
                state_nxt   = S_SHIFT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // issue the probe read
      S_RD: begin
        rd_en     = 1'b1;
        rd_addr   = g_r;
        state_nxt = S_CMP;
      end

      // compare probe against the key and narrow the limits
      S_CMP: begin
        if (probe_size == req_r.size_key) begin
          hit_nxt  = 1'b1;
          pos_calc = CW'(g_r);
        end else if (lo_r < hi_r) begin
          if (probe_size > req_r.size_key) begin
            hi_nxt = (g_r == '0) ? '0 : g_r - AW'(1);
          end else begin
            lo_nxt = g_r + AW'(1);
          end
          mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
          g_nxt   = mid_sum[AW:1];
        end else begin
          pos_calc = (probe_size < req_r.size_key) ? CW'(g_r) + CW'(1) : CW'(g_r);
        end
        pos_nxt = pos_calc;
        if ((probe_size != req_r.size_key) && (lo_r < hi_r)) begin
          state_nxt = S_RD;
        end else if (req_r.req_type == sfst_pkg::REQ_FIND) begin
          state_nxt = S_DONE;
        end else begin
          up_nxt      = 1'b1;
          rd_ptr_nxt  = cnt_m1;
          last_nxt    = AW'(pos_calc);
          rd_more_nxt = count_r > pos_calc;
          state_nxt   = S_SHIFT;
        end
      end

      // move entries one slot, read of one overlapping write of the previous
      S_SHIFT: begin
        if (wr_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_addr_r;
          wr_data = mem_q;
        end
        if (rd_more_r) begin
          rd_en       = 1'b1;
          rd_addr     = rd_ptr_r;
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = up_r ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
          rd_ptr_nxt  = up_r ? rd_ptr_r - AW'(1) : rd_ptr_r + AW'(1);
          rd_more_nxt = rd_ptr_r != last_r;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            if (up_r) begin
              wr_en     = 1'b1;
              wr_addr   = AW'(pos_r);
              wr_data   = {req_r.size_key, req_r.space_handle};
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_DONE;
          end
        end
      end

      // hold the result until the output register takes it
      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    g_r       <= g_nxt;
    pos_r     <= pos_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    last_r    <= last_nxt;
    up_r      <= up_nxt;
    rd_more_r <= rd_more_nxt;
    wr_pend_r <= wr_pend_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

  // entry memory, size in the upper half and handle in the lower half
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // result fields
  logic find_hit;
  logic has_index;

  assign find_hit  = (req_r.req_type == sfst_pkg::REQ_FIND) && hit_r;
  assign has_index = (status_r == sfst_pkg::ST_OK) &&
                     ((req_r.req_type == sfst_pkg::REQ_FIND) ||
                      (req_r.req_type == sfst_pkg::REQ_INSERT));

  assign idle             = (state_r == S_IDLE);
  assign rsp_valid        = (state_r == S_DONE);
  assign rsp_flags.found  = find_hit;
  assign rsp_flags.status = status_r;
  assign rsp_index        = has_index ? pos_r : '0;
  assign rsp_handle       = find_hit ? mem_q[HW-1:0] : '0;
  assign rsp_count        = count_r;

endmodule

>>> rtl/core/sfst_checker.sv
// sfst_checker: port level checks of the free space table, bound to the top level
// depends on sfst_pkg and size_sorted_free_space_table

module sfst_checker #(
  parameter int DEPTH = sfst_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_found,
  input logic [$clog2(DEPTH+1)-1:0]    out_result_index,
  input logic [sfst_pkg::HANDLE_W-1:0] out_result_handle,
  input logic [$clog2(DEPTH+1)-1:0]    out_entry_count,
  input logic [sfst_pkg::STATUS_W-1:0] out_status
);

  localparam int CW = $clog2(DEPTH + 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_index) &&
      $stable(out_entry_count) && $stable(out_status) && $stable(out_found)))
    else $error("stalled result changed");

  // a request never completes in the cycle it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken without going busy");

  // entry count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CW'(DEPTH)))
    else $error("entry count beyond depth");

  // a match points at a held entry
  a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |->
      ((out_status == sfst_pkg::ST_OK) && (out_result_index < out_entry_count)))
    else $error("match outside held entries");

  // error results carry no match and no handle
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != sfst_pkg::ST_OK)) |->
      (!out_found && (out_result_handle == '0) && (out_result_index == '0)))
    else $error("error result carries data");

endmodule

bind size_sorted_free_space_table sfst_checker #(
  .DEPTH(DEPTH)
) u_sfst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_result_index (out_result_index),
  .out_result_handle(out_result_handle),
  .out_entry_count  (out_entry_count),
  .out_status       (out_status)
);
